// File: hdl/uuenc_pkg.sv
package uuenc_pkg;

	localparam int unsigned GROUP_BITS = 6;
	localparam int unsigned CHAR_BITS  = 7;

	localparam logic [CHAR_BITS-1:0] ZERO_CHAR   = 7'd96;
	localparam logic [CHAR_BITS-1:0] CHAR_OFFSET = 7'd32;

	// leftover bit counts the encoder can hold
	typedef enum logic [1:0] {
		LEFT_NONE = 2'd0,
		LEFT_TWO  = 2'd1,
		LEFT_FOUR = 2'd2
	} left_cnt_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} char_beat_t;

	function automatic logic [CHAR_BITS-1:0] group_to_char(input logic [GROUP_BITS-1:0] g);
		logic [CHAR_BITS-1:0] c;
		if (g == '0) begin
			c = ZERO_CHAR;
		end else begin
			c = {1'b0, g} + CHAR_OFFSET;
		end
		return c;
	endfunction

endpackage

// File: hdl/uu_char_stream_encoder_core.sv
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_stall  | data_byte[7:0], end_of_message
// output  | out       | out_valid / out_stall| code_char[6:0], last_char
//
// A byte is registered, then encoded into one or two characters once the buffer has room for two.
// Characters drain through a four-entry buffer, one per cycle while out_stall is low;
// the single output port limits the sustained byte rate.
// A byte passes the input register and then the buffer before its first character leaves.
// Reset (arst_n low) empties the buffer and clears the leftover bits.
// A stalled output backs up into the buffer and then into in_stall.
module uu_char_stream_encoder_core
	import uuenc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_message,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CHAR_BITS-1:0] code_char,
	output logic                 last_char
);

	localparam int unsigned BUF_DEPTH = 4;
	localparam int unsigned PTR_BITS  = $clog2(BUF_DEPTH);
	localparam int unsigned CNT_BITS  = $clog2(BUF_DEPTH + 1);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eom_s1;

	logic [3:0]           left_bits_q;
	left_cnt_t            left_cnt_q;

	char_beat_t           buf_q [BUF_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [CNT_BITS-1:0]  count_q;

	logic                 push;
	logic                 pop;
	logic                 two_chars;
	logic [GROUP_BITS-1:0] grp0;
	logic [GROUP_BITS-1:0] grp1;
	logic [3:0]           next_bits;
	left_cnt_t            next_cnt;
	logic [CNT_BITS-1:0]  push_n;

	// encode the registered byte against the leftover bits
	always_comb begin
		grp0      = byte_s1[7:2];
		grp1      = {byte_s1[1:0], 4'b0000};
		two_chars = eom_s1;
		next_bits = {2'b00, byte_s1[1:0]};
		next_cnt  = LEFT_TWO;
		case (left_cnt_q)
			LEFT_NONE: begin
				grp0      = byte_s1[7:2];
				grp1      = {byte_s1[1:0], 4'b0000};
				two_chars = eom_s1;
				next_bits = {2'b00, byte_s1[1:0]};
				next_cnt  = LEFT_TWO;
			end
			LEFT_TWO: begin
				grp0      = {left_bits_q[1:0], byte_s1[7:4]};
				grp1      = {byte_s1[3:0], 2'b00};
				two_chars = eom_s1;
				next_bits = byte_s1[3:0];
				next_cnt  = LEFT_FOUR;
			end
			LEFT_FOUR: begin
				grp0      = {left_bits_q[3:0], byte_s1[7:6]};
				grp1      = byte_s1[5:0];
				two_chars = 1'b1;
				next_bits = 4'b0000;
				next_cnt  = LEFT_NONE;
			end
			default: begin
				grp0      = byte_s1[7:2];
				grp1      = {byte_s1[1:0], 4'b0000};
				two_chars = eom_s1;
				next_bits = {2'b00, byte_s1[1:0]};
				next_cnt  = LEFT_TWO;
			end
		endcase
		if (eom_s1) begin
			next_bits = 4'b0000;
			next_cnt  = LEFT_NONE;
		end
	end

	// room for two characters is needed before a byte moves on
	assign push     = valid_s1 && (count_q <= CNT_BITS'(BUF_DEPTH - 2));
	assign in_stall = valid_s1 && !push;
	assign pop      = out_valid && !out_stall;
	assign push_n   = push ? (two_chars ? CNT_BITS'(2) : CNT_BITS'(1)) : '0;

	assign out_valid = (count_q != '0);
	assign code_char = buf_q[rd_ptr_q].code;
	assign last_char = buf_q[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			left_bits_q <= '0;
			left_cnt_q  <= LEFT_NONE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (push) begin
				left_bits_q <= next_bits;
				left_cnt_q  <= next_cnt;
				wr_ptr_q    <= wr_ptr_q + (two_chars ? PTR_BITS'(2) : PTR_BITS'(1));
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + push_n - (pop ? CNT_BITS'(1) : CNT_BITS'(0));
		end
	end

	// payload: hold the byte while stalled, write characters on push
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			eom_s1  <= end_of_message;
		end
		if (push) begin
			buf_q[wr_ptr_q].code <= group_to_char(grp0);
			buf_q[wr_ptr_q].last <= 1'b0;
			if (two_chars) begin
				buf_q[wr_ptr_q + PTR_BITS'(1)].code <= group_to_char(grp1);
				buf_q[wr_ptr_q + PTR_BITS'(1)].last <= eom_s1;
			end
		end
	end

endmodule

// File: tb/uuenc_stream_checker.sv
module uuenc_stream_checker
	import uuenc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_message,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [CHAR_BITS-1:0] code_char,
	input  logic                 last_char,
	output int unsigned          err_count,
	output int unsigned          chars_pending,
	output int unsigned          chars_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [3:0] carry_bits;
	left_cnt_t  carry_cnt;
	char_beat_t expected_chars[$];

	initial begin
		err_count     = 0;
		chars_pending = 0;
		chars_checked = 0;
	end

	function automatic logic [CHAR_BITS-1:0] char_of_group(input logic [GROUP_BITS-1:0] g);
		return (g == '0) ? ZERO_CHAR : CHAR_OFFSET + CHAR_BITS'(g);
	endfunction

	// append the byte after the carried bits, cut 6-bit groups, flush on message end
	function automatic void encode_byte(input logic [7:0] b, input logic eom);
		logic [11:0] acc;
		int unsigned total;
		char_beat_t  beat;
		char_beat_t  beats[$];
		case (carry_cnt)
			LEFT_TWO: begin
				acc   = {2'b00, carry_bits[1:0], b};
				total = 10;
			end
			LEFT_FOUR: begin
				acc   = {carry_bits, b};
				total = 12;
			end
			default: begin
				acc   = {4'h0, b};
				total = 8;
			end
		endcase
		while (total >= GROUP_BITS) begin
			beat.code = char_of_group(GROUP_BITS'(acc >> (total - GROUP_BITS)));
			beat.last = 1'b0;
			beats.push_back(beat);
			total -= GROUP_BITS;
		end
		if (eom) begin
			if (total != 0) begin
				beat.code = char_of_group(GROUP_BITS'(acc << (GROUP_BITS - total)));
				beat.last = 1'b1;
				beats.push_back(beat);
			end else begin
				beat = beats.pop_back();
				beat.last = 1'b1;
				beats.push_back(beat);
			end
			carry_bits = '0;
			carry_cnt  = LEFT_NONE;
		end else begin
			carry_bits = 4'(acc);
			carry_cnt  = (total == 4) ? LEFT_FOUR : (total == 2) ? LEFT_TWO : LEFT_NONE;
		end
		foreach (beats[i])
			expected_chars.push_back(beats[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		char_beat_t want;
		if (!arst_n) begin
			carry_bits = '0;
			carry_cnt  = LEFT_NONE;
			expected_chars.delete();
		end else begin
			// check output first: a byte taken at this edge cannot have produced it
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected char beat: code_char=%0d last_char=%0b",
						code_char, last_char);
					err_count++;
				end else begin
					want = expected_chars.pop_front();
					chars_checked++;
					if (code_char !== want.code) begin
						$error("code_char mismatch: expected %0d, actual %0d",
							want.code, code_char);
						err_count++;
					end
					if (last_char !== want.last) begin
						$error("last_char mismatch: expected %0b, actual %0b",
							want.last, last_char);
						err_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				encode_byte(data_byte, end_of_message);
		end
		chars_pending = expected_chars.size();
	end

endmodule

// File: tb/tb_top.sv
module tb_top
	import uuenc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_BYTES = 500;
	localparam int unsigned QUIET_TAIL   = 60;
	localparam int unsigned LONG_HOLD    = 80;
	localparam int unsigned PAUSE_AT     = 300;
	localparam int unsigned HOLD_AT      = 120;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// bit 8 marks the end of a message
	localparam int unsigned N_DIRECTED = 22;
	localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
		{1'b1, 8'h00},
		{1'b1, 8'hFF},
		{1'b0, 8'hFF}, {1'b1, 8'h00},
		{1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b1, 8'h00},
		{1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
		{1'b0, 8'hA5}, {1'b0, 8'h5A}, {1'b0, 8'hC3}, {1'b1, 8'h3C},
		{1'b0, 8'h04}, {1'b0, 8'h10}, {1'b1, 8'h41},
		{1'b0, 8'h12}, {1'b0, 8'h34}, {1'b0, 8'h56}, {1'b0, 8'h78}, {1'b1, 8'h9A}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte = 8'h00;
	logic                 end_of_message = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CHAR_BITS-1:0] code_char;
	logic                 last_char;

	int unsigned err_count;
	int unsigned chars_pending;
	int unsigned chars_checked;
	int unsigned bytes_sent = 0;
	int unsigned messages_sent = 0;
	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;
	bit          long_hold_done = 1'b0;

	uu_char_stream_encoder_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code_char      (code_char),
		.last_char      (last_char)
	);

	uuenc_stream_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code_char      (code_char),
		.last_char      (last_char),
		.err_count      (err_count),
		.chars_pending  (chars_pending),
		.chars_checked  (chars_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// call at a rising edge; returns at the edge where the beat is taken
	task automatic send_byte(input logic [7:0] b, input logic eom);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		end_of_message <= eom;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		if (eom)
			messages_sent++;
	endtask

	task automatic send_message(input int unsigned len);
		logic [7:0] b;
		for (int unsigned i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b, i == len - 1);
		end
	endtask

	initial begin : sender
		int unsigned r;
		int unsigned len;
		bit          paused;
		paused = 1'b0;
		wait (arst_n);
		@(posedge clk);
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		while (bytes_sent < N_DIRECTED + RANDOM_BYTES) begin
			r = $urandom_range(0, 9);
			len = (r < 6) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(7, 16)
				: $urandom_range(17, 40);
			send_message(len);
			if (bytes_sent >= N_DIRECTED + RANDOM_BYTES - QUIET_TAIL)
				quiet = 1'b1;
			// drain everything before going on; let the last beat reach the checker first
			if (!paused && bytes_sent >= PAUSE_AT) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				wait (chars_pending == 0);
				@(posedge clk);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		wait (chars_pending == 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d messages, checked %0d characters.",
			bytes_sent, messages_sent, chars_checked);
		$display("Covered idle and stall bursts, a long output hold and a drain pause.");
		if (err_count == 0 && chars_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : receiver
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && bytes_sent >= HOLD_AT) begin
				// hold off long enough for the buffer to fill and stall the input
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

endmodule

// File: sim.f
hdl/uuenc_pkg.sv
hdl/uu_char_stream_encoder_core.sv
tb/uuenc_stream_checker.sv
tb/tb_top.sv
